// ----- design/wxd_pkg.sv -----
// ----------------------------------------------------------------------------
// Windowed extremum detector package
// Shared constants, codes and types for the detector and its sample store.
// ----------------------------------------------------------------------------
package wxd_pkg;

    localparam int MAX_STEP   = 15;
    localparam int STEP_W     = 4;
    localparam int INDEX_BITS = 20;
    localparam int VALUE_W    = 32;
    localparam int SAMPLE_W   = 2 * VALUE_W;
    localparam int WIN_DEPTH  = 32;
    localparam int WIN_AW     = 5;
    localparam int SEQ_W      = 5;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [STEP_W-1:0]     STEP_RESET = STEP_W'(3);
    localparam logic [INDEX_BITS-1:0] COUNT_MAX  = {INDEX_BITS{1'b1}};
    localparam logic                  REG_STEP   = 1'b0;

    typedef enum logic [1:0] {
        KIND_LOW  = 2'd0,
        KIND_HIGH = 2'd1,
        KIND_END  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        TAG_NONE,
        TAG_CAND,
        TAG_OLD,
        TAG_NEW
    } t_tag;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_ISSUE,
        S_DRAIN,
        S_EMIT_LO,
        S_EMIT_HI,
        S_ADV,
        S_END
    } t_state;

endpackage

// ----- design/windowed_extremum_detector.sv -----
// ----------------------------------------------------------------------------
// Windowed extremum detector
// Finds low and high extremum samples of a series over a sliding window.
// ----------------------------------------------------------------------------
// The input channel takes one sample word (high value, low value, series end
// flag); the output channel gives result words, each marked with its kind.
// The register step (APB addresses 0 to 3) sets the neighbours compared per side.
// Each accepted word is written to a 32-entry circular sample memory. The
// candidate step samples back is then judged by reading it and its 2*step
// neighbours, one memory read per cycle. A word too early in its series to
// have a candidate is passed over. A low result leaves before the high
// result of the same candidate. A series end word also judges each
// pending candidate in turn and adds an end record.
// The input accepts a new word only when the previous one is fully worked
// off; a result waits in the output register while the receiver stalls, and
// the next word may be accepted meanwhile. The final result of a word has
// last_of_run set. Reset sets step to 3 and starts a new series at index 0;
// the sample memory needs no clearing.
// ----------------------------------------------------------------------------
module windowed_extremum_detector (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic signed [wxd_pkg::VALUE_W-1:0] i_high_value,
    input  logic signed [wxd_pkg::VALUE_W-1:0] i_low_value,
    input  logic                             i_series_end,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [1:0]                       o_kind,
    output logic [wxd_pkg::INDEX_BITS-1:0]   o_position,
    output logic signed [wxd_pkg::VALUE_W-1:0] o_peak_high,
    output logic signed [wxd_pkg::VALUE_W-1:0] o_peak_low,
    output logic                             o_no_low_found,
    output logic                             o_no_high_found,
    output logic                             o_last_of_run,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [wxd_pkg::PADDR_W-1:0]      paddr,
    input  logic [wxd_pkg::PDATA_W-1:0]      pwdata,
    output logic [wxd_pkg::PDATA_W-1:0]      prdata,
    output logic                             pready
);

    import wxd_pkg::*;

    t_state                 r_state, n_state;
    logic [STEP_W-1:0]      r_step, n_step;
    logic [STEP_W-1:0]      r_s, n_s;
    logic [STEP_W-1:0]      r_d, n_d;
    logic [SEQ_W-1:0]       r_j, n_j;
    logic [SEQ_W-1:0]       r_jlast, n_jlast;
    t_tag                   r_tag, n_tag;
    logic [WIN_AW-1:0]      r_wp, n_wp;
    logic [INDEX_BITS-1:0]  r_count, n_count;
    logic [INDEX_BITS-1:0]  r_n, n_n;
    logic                   r_end, n_end;
    logic                   r_low_seen, n_low_seen;
    logic                   r_high_seen, n_high_seen;
    logic                   r_is_low, n_is_low;
    logic                   r_is_high, n_is_high;
    logic signed [VALUE_W-1:0] r_ch, n_ch;
    logic signed [VALUE_W-1:0] r_cl, n_cl;

    logic                   r_ovalid, n_ovalid;
    t_kind                  r_okind, n_okind;
    logic [INDEX_BITS-1:0]  r_opos, n_opos;
    logic signed [VALUE_W-1:0] r_ohigh, n_ohigh;
    logic signed [VALUE_W-1:0] r_olow, n_olow;
    logic                   r_onolow, n_onolow;
    logic                   r_onohigh, n_onohigh;
    logic                   r_olast, n_olast;

    logic                   ram_we;
    logic [WIN_AW-1:0]      ram_waddr;
    logic [WIN_AW-1:0]      ram_raddr;
    logic [SAMPLE_W-1:0]    ram_rdata;
    logic signed [VALUE_W-1:0] rd_high;
    logic signed [VALUE_W-1:0] rd_low;
    logic [STEP_W-1:0]      s_eff;
    logic [STEP_W-1:0]      newer_cnt;
    logic [SEQ_W-1:0]       offset;
    logic                   in_acc;
    logic                   cfg_wr;
    logic                   out_free;

    wxd_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WIN_DEPTH)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata ({i_high_value, i_low_value}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign in_acc    = i_valid && o_ready;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign out_free  = !r_ovalid || i_ready;
    assign rd_high   = ram_rdata[SAMPLE_W-1:VALUE_W];
    assign rd_low    = ram_rdata[VALUE_W-1:0];
    assign ram_we    = in_acc;
    assign ram_waddr = r_wp + WIN_AW'(1);
    assign ram_raddr = r_wp - WIN_AW'(offset);

    assign s_eff = (r_step == '0) ? STEP_W'(1) :
                   (r_step > STEP_W'(MAX_STEP)) ? STEP_W'(MAX_STEP) : r_step;
    assign newer_cnt = (r_d < r_s) ? r_d : r_s;

    always_comb begin
        if (r_j <= SEQ_W'(r_s)) begin
            offset = SEQ_W'(r_d) + r_j;
        end else begin
            offset = SEQ_W'(r_d) + SEQ_W'(r_s) - r_j;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_s         = r_s;
        n_d         = r_d;
        n_j         = r_j;
        n_jlast     = r_jlast;
        n_tag       = TAG_NONE;
        n_wp        = r_wp;
        n_count     = r_count;
        n_n         = r_n;
        n_end       = r_end;
        n_low_seen  = r_low_seen;
        n_high_seen = r_high_seen;
        n_is_low    = r_is_low;
        n_is_high   = r_is_high;
        n_ch        = r_ch;
        n_cl        = r_cl;
        n_ovalid    = r_ovalid && !i_ready;
        n_okind     = r_okind;
        n_opos      = r_opos;
        n_ohigh     = r_ohigh;
        n_olow      = r_olow;
        n_onolow    = r_onolow;
        n_onohigh   = r_onohigh;
        n_olast     = r_olast;
        o_ready     = 1'b0;

        if (cfg_wr && paddr[PADDR_W-1] == REG_STEP) begin
            n_step = pwdata[STEP_W-1:0];
        end

        case (r_tag)
            TAG_CAND: begin
                n_ch      = rd_high;
                n_cl      = rd_low;
                n_is_low  = 1'b1;
                n_is_high = 1'b1;
            end
            TAG_OLD: begin
                if (!(r_cl < rd_low)) begin
                    n_is_low = 1'b0;
                end
                if (!(r_ch > rd_high)) begin
                    n_is_high = 1'b0;
                end
            end
            TAG_NEW: begin
                if (!(r_cl <= rd_low)) begin
                    n_is_low = 1'b0;
                end
                if (!(r_ch >= rd_high)) begin
                    n_is_high = 1'b0;
                end
            end
            default: begin
            end
        endcase

        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_wp  = r_wp + WIN_AW'(1);
                    n_n   = r_count;
                    n_s   = s_eff;
                    n_d   = s_eff;
                    n_end = i_series_end;
                    if (i_series_end) begin
                        n_count = '0;
                    end else if (r_count != COUNT_MAX) begin
                        n_count = r_count + INDEX_BITS'(1);
                    end
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_n >= INDEX_BITS'(r_s) + INDEX_BITS'(r_d)) begin
                    n_j     = '0;
                    n_jlast = SEQ_W'(r_s) + SEQ_W'(newer_cnt);
                    n_state = S_ISSUE;
                end else begin
                    n_state = S_ADV;
                end
            end
            S_ISSUE: begin
                if (r_j == '0) begin
                    n_tag = TAG_CAND;
                end else if (r_j <= SEQ_W'(r_s)) begin
                    n_tag = TAG_OLD;
                end else begin
                    n_tag = TAG_NEW;
                end
                if (r_j == r_jlast) begin
                    n_state = S_DRAIN;
                end else begin
                    n_j = r_j + SEQ_W'(1);
                end
            end
            S_DRAIN: begin
                n_state = S_EMIT_LO;
            end
            S_EMIT_LO: begin
                if (!r_is_low) begin
                    n_state = S_EMIT_HI;
                end else if (out_free) begin
                    n_ovalid   = 1'b1;
                    n_okind    = KIND_LOW;
                    n_opos     = r_n - INDEX_BITS'(r_d);
                    n_ohigh    = r_ch;
                    n_olow     = r_cl;
                    n_onolow   = 1'b0;
                    n_onohigh  = 1'b0;
                    n_olast    = !r_end && !r_is_high;
                    n_low_seen = 1'b1;
                    n_state    = S_EMIT_HI;
                end
            end
            S_EMIT_HI: begin
                if (!r_is_high) begin
                    n_state = S_ADV;
                end else if (out_free) begin
                    n_ovalid    = 1'b1;
                    n_okind     = KIND_HIGH;
                    n_opos      = r_n - INDEX_BITS'(r_d);
                    n_ohigh     = r_ch;
                    n_olow      = r_cl;
                    n_onolow    = 1'b0;
                    n_onohigh   = 1'b0;
                    n_olast     = !r_end;
                    n_high_seen = 1'b1;
                    n_state     = S_ADV;
                end
            end
            S_ADV: begin
                n_is_low  = 1'b0;
                n_is_high = 1'b0;
                if (r_end && r_d != '0) begin
                    n_d     = r_d - STEP_W'(1);
                    n_state = S_CHECK;
                end else if (r_end) begin
                    n_state = S_END;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_END: begin
                if (out_free) begin
                    n_ovalid    = 1'b1;
                    n_okind     = KIND_END;
                    n_opos      = '0;
                    n_ohigh     = '0;
                    n_olow      = '0;
                    n_onolow    = !r_low_seen;
                    n_onohigh   = !r_high_seen;
                    n_olast     = 1'b1;
                    n_low_seen  = 1'b0;
                    n_high_seen = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= STEP_RESET;
            r_tag       <= TAG_NONE;
            r_wp        <= '0;
            r_count     <= '0;
            r_end       <= 1'b0;
            r_low_seen  <= 1'b0;
            r_high_seen <= 1'b0;
            r_is_low    <= 1'b0;
            r_is_high   <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_tag       <= n_tag;
            r_wp        <= n_wp;
            r_count     <= n_count;
            r_end       <= n_end;
            r_low_seen  <= n_low_seen;
            r_high_seen <= n_high_seen;
            r_is_low    <= n_is_low;
            r_is_high   <= n_is_high;
            r_ovalid    <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s       <= n_s;
        r_d       <= n_d;
        r_j       <= n_j;
        r_jlast   <= n_jlast;
        r_n       <= n_n;
        r_ch      <= n_ch;
        r_cl      <= n_cl;
        r_okind   <= n_okind;
        r_opos    <= n_opos;
        r_ohigh   <= n_ohigh;
        r_olow    <= n_olow;
        r_onolow  <= n_onolow;
        r_onohigh <= n_onohigh;
        r_olast   <= n_olast;
    end

    assign o_valid         = r_ovalid;
    assign o_kind          = r_okind;
    assign o_position      = r_opos;
    assign o_peak_high     = r_ohigh;
    assign o_peak_low      = r_olow;
    assign o_no_low_found  = r_onolow;
    assign o_no_high_found = r_onohigh;
    assign o_last_of_run   = r_olast;

    assign pready = 1'b1;
    assign prdata = (paddr[PADDR_W-1] == REG_STEP) ? PDATA_W'(r_step) : '0;

endmodule

// ----- design/wxd_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module wxd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
